// File: src/mfnh_pkg.sv
// ---------------------------------------------------------------------------
// Marker-framed name header parser: shared package
// Beat types, configuration register map, parser phase encoding and the
// control and status groups passed between the framing and name blocks.
// ---------------------------------------------------------------------------
package mfnh_pkg;

	// Upper bound on the accepted filename length.
	localparam logic [7:0] MAX_NAME_BYTES = 8'd255;

	// Configuration register indexes (byte address is 8 times the index).
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_OPEN_MARKER  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OPEN_LENGTH  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CLOSE_MARKER = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CLOSE_LENGTH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NAME_LIMIT   = 3'd4;

	localparam int unsigned PADDR_W = 6;
	localparam int unsigned PDATA_W = 64;

	// One input beat: a buffer byte and its last flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_final;
	} in_beat_t;

	// One result beat.
	typedef struct packed {
		logic       found;
		logic [7:0] name_bytes;
		logic [8:0] header_bytes;
	} out_beat_t;

	// Configuration register contents.
	typedef struct packed {
		logic [63:0] open_marker;
		logic [3:0]  open_length;
		logic [63:0] close_marker;
		logic [3:0]  close_length;
		logic [7:0]  name_limit;
	} cfg_t;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_OPEN,
		PH_SCAN,
		PH_DONE
	} phase_t;

	// Control from the framing logic to the name checker.
	typedef struct packed {
		logic       feed;
		logic       clear;
		logic [7:0] data;
	} name_ctl_t;

	// Name status as it stands after this cycle's byte.
	typedef struct packed {
		logic       ok;
		logic [8:0] count;
	} name_stat_t;

endpackage

// File: src/mfnh_cfg_regs.sv
// ---------------------------------------------------------------------------
// Marker-framed name header parser: configuration registers
// APB-style register file holding the marker and length settings.
// ---------------------------------------------------------------------------
module mfnh_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mfnh_pkg::PADDR_W-1:0]  paddr,
	input  logic [mfnh_pkg::PDATA_W-1:0]  pwdata,
	output logic [mfnh_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output mfnh_pkg::cfg_t                cfg
);

	mfnh_pkg::cfg_t                    cfg_q;
	logic [mfnh_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[mfnh_pkg::PADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	// Register writes; indexes past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.open_marker  <= '0;
			cfg_q.open_length  <= '0;
			cfg_q.close_marker <= '0;
			cfg_q.close_length <= 4'd1;
			cfg_q.name_limit   <= 8'd255;
		end else if (wr_en) begin
			case (reg_idx)
				mfnh_pkg::REG_OPEN_MARKER:  cfg_q.open_marker  <= pwdata;
				mfnh_pkg::REG_OPEN_LENGTH:  cfg_q.open_length  <= pwdata[3:0];
				mfnh_pkg::REG_CLOSE_MARKER: cfg_q.close_marker <= pwdata;
				mfnh_pkg::REG_CLOSE_LENGTH: cfg_q.close_length <= pwdata[3:0];
				mfnh_pkg::REG_NAME_LIMIT:   cfg_q.name_limit   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (reg_idx)
			mfnh_pkg::REG_OPEN_MARKER:  prdata = cfg_q.open_marker;
			mfnh_pkg::REG_OPEN_LENGTH:  prdata = 64'(cfg_q.open_length);
			mfnh_pkg::REG_CLOSE_MARKER: prdata = cfg_q.close_marker;
			mfnh_pkg::REG_CLOSE_LENGTH: prdata = 64'(cfg_q.close_length);
			mfnh_pkg::REG_NAME_LIMIT:   prdata = 64'(cfg_q.name_limit);
			default:                    prdata = '0;
		endcase
	end

endmodule

// File: src/mfnh_name_check.sv
// ---------------------------------------------------------------------------
// Marker-framed name header parser: filename checker
// Tracks length, last byte and UTF-8 decode state of the name bytes and
// flags forbidden characters and malformed sequences as they stream.
// ---------------------------------------------------------------------------
module mfnh_name_check (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfnh_pkg::name_ctl_t  ctl,
	output mfnh_pkg::name_stat_t stat
);

	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0]  rem;
		logic [20:0] acc;
		logic [1:0]  cls;
		logic [8:0]  count;
		logic [7:0]  last;
		logic        dots;
		logic        invalid;
	} name_state_t;

	localparam name_state_t NAME_RESET = '{
		rem: 2'd0, acc: 21'd0, cls: 2'd0, count: 9'd0,
		last: 8'd0, dots: 1'b1, invalid: 1'b0
	};

	name_state_t st_q;
	name_state_t nx;
	logic [7:0]  b;
	logic [20:0] code;
	logic [1:0]  rem_dec;

	// Bytes not allowed in a filename outside a multibyte sequence.
	function automatic logic forbidden(input logic [7:0] v);
		return (v < 8'h20) ||
		       (v inside {8'h7f, 8'h2f, 8'h5c, 8'h3a, 8'h3c, 8'h3e, 8'h22, 8'h7c, 8'h3f, 8'h2a});
	endfunction

	// Smallest code point allowed for each sequence length.
	function automatic logic [20:0] class_min(input logic [1:0] c);
		logic [20:0] m;
		case (c)
			2'd0:    m = 21'h0;
			2'd1:    m = 21'h80;
			2'd2:    m = 21'h800;
			default: m = 21'h10000;
		endcase
		return m;
	endfunction

	assign b       = ctl.data;
	assign code    = {st_q.acc[14:0], b[5:0]};
	assign rem_dec = st_q.rem - 2'd1;

	// Next state for one name byte.
	always_comb begin
		nx = st_q;
		if (ctl.feed) begin
			nx.count = st_q.count + 9'd1;
			nx.last  = b;
			nx.dots  = st_q.dots && (b == CH_DOT);
			if (!st_q.invalid) begin
				if (st_q.rem == 2'd0) begin
					if (forbidden(b)) begin
						nx.invalid = 1'b1;
					end else if (b inside {[8'hc2:8'hdf]}) begin
						nx.rem = 2'd1;
						nx.acc = 21'(b[4:0]);
						nx.cls = 2'd1;
					end else if (b inside {[8'he0:8'hef]}) begin
						nx.rem = 2'd2;
						nx.acc = 21'(b[3:0]);
						nx.cls = 2'd2;
					end else if (b inside {[8'hf0:8'hf4]}) begin
						nx.rem = 2'd3;
						nx.acc = 21'(b[2:0]);
						nx.cls = 2'd3;
					end else if (b >= 8'h80) begin
						nx.invalid = 1'b1;
					end
				end else if (b[7:6] != 2'b10) begin
					nx.invalid = 1'b1;
				end else begin
					nx.acc = code;
					nx.rem = rem_dec;
					// Sequence complete: reject overlongs, surrogates, out of
					// range values and C1 controls.
					if (rem_dec == 2'd0) begin
						if (code < class_min(st_q.cls) || code > 21'h10ffff ||
						    code inside {[21'hd800:21'hdfff]} ||
						    code inside {[21'h80:21'h9f]}) begin
							nx.invalid = 1'b1;
						end
					end
				end
			end
		end
	end

	// Name state register; a new buffer starts from the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= NAME_RESET;
		end else if (ctl.clear) begin
			st_q <= NAME_RESET;
		end else begin
			st_q <= nx;
		end
	end

	// Name acceptance apart from the length limit.
	assign stat.count = nx.count;
	assign stat.ok    = (nx.count != 9'd0) && !nx.invalid && (nx.rem == 2'd0) &&
	                    !(nx.dots && nx.count <= 9'd2) &&
	                    (nx.last != CH_DOT) && (nx.last != CH_SPACE);

endmodule

// File: src/mfnh_frame.sv
// ---------------------------------------------------------------------------
// Marker-framed name header parser: framing logic
// Matches the opening marker, slides the closing-marker window over the
// buffer, passes name bytes to the checker and decides the result.
// ---------------------------------------------------------------------------
module mfnh_frame #(
	parameter int unsigned MAX_MARKER_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  mfnh_pkg::in_beat_t  beat,
	input  mfnh_pkg::cfg_t      cfg,
	output logic                emit,
	output mfnh_pkg::out_beat_t result
);

	localparam int unsigned WIN_W   = 8 * MAX_MARKER_BYTES;
	localparam int unsigned MIDX_W  = (MAX_MARKER_BYTES > 1) ? $clog2(MAX_MARKER_BYTES) : 1;
	localparam logic [3:0]  MAX_LEN = 4'(MAX_MARKER_BYTES);

	mfnh_pkg::phase_t     phase_q, phase_nx, phase_eff;
	logic [8:0]           pos_q, pos_nx, pos_eff, pos_inc;
	logic [WIN_W-1:0]     win_q, win_nx, win_eff, win_shift, win_mask;
	logic [3:0]           olen, clen;
	logic [7:0]           lim, want;
	logic [MIDX_W-1:0]    midx;
	logic                 match;
	mfnh_pkg::name_ctl_t  name_ctl;
	mfnh_pkg::name_stat_t name_stat;

	// Effective lengths after clamping.
	assign olen = (cfg.open_length > MAX_LEN) ? MAX_LEN : cfg.open_length;
	assign clen = (cfg.close_length > MAX_LEN) ? MAX_LEN : cfg.close_length;
	assign lim  = (cfg.name_limit > mfnh_pkg::MAX_NAME_BYTES) ?
	              mfnh_pkg::MAX_NAME_BYTES : cfg.name_limit;

	// A shortened opening marker may already be complete.
	always_comb begin
		phase_eff = phase_q;
		pos_eff   = pos_q;
		win_eff   = win_q;
		if (phase_q == mfnh_pkg::PH_OPEN && pos_q >= 9'(olen)) begin
			phase_eff = mfnh_pkg::PH_SCAN;
			pos_eff   = '0;
			win_eff   = '0;
		end
	end

	assign pos_inc = pos_eff + 9'd1;
	assign midx    = pos_eff[MIDX_W-1:0];
	assign want    = cfg.open_marker[8*midx +: 8];

	// Closing window: new byte enters at the top of the active length.
	assign win_mask  = (clen >= MAX_LEN) ? '1 :
	                   ((WIN_W'(1) << (8 * clen)) - WIN_W'(1));
	assign win_shift = ((win_eff >> 8) |
	                   (WIN_W'(beat.data_byte) << (8 * (clen - 4'd1)))) & win_mask;
	assign match     = (pos_inc >= 9'(clen)) &&
	                   (win_shift == (cfg.close_marker[WIN_W-1:0] & win_mask));

	// Decision and next state for one byte.
	always_comb begin
		phase_nx       = phase_eff;
		pos_nx         = pos_eff;
		win_nx         = win_eff;
		emit           = 1'b0;
		result         = '0;
		name_ctl.feed  = 1'b0;
		name_ctl.clear = 1'b0;
		name_ctl.data  = win_eff[7:0];
		if (step) begin
			if (phase_q != mfnh_pkg::PH_DONE) begin
				if (clen == 4'd0) begin
					emit = 1'b1;
				end else if (phase_eff == mfnh_pkg::PH_OPEN) begin
					if (want != beat.data_byte) begin
						emit = 1'b1;
					end else if (pos_inc >= 9'(olen)) begin
						phase_nx = mfnh_pkg::PH_SCAN;
						pos_nx   = '0;
						win_nx   = '0;
					end else begin
						pos_nx = pos_inc;
					end
				end else begin
					name_ctl.feed = (pos_eff >= 9'(clen));
					win_nx        = win_shift;
					if (match) begin
						emit = 1'b1;
						if (name_stat.ok && name_stat.count <= 9'(lim)) begin
							result.found        = 1'b1;
							result.name_bytes   = name_stat.count[7:0];
							result.header_bytes = 9'(olen) + name_stat.count + 9'(clen);
						end
					end else begin
						pos_nx = pos_inc;
						if (pos_inc >= 9'(lim) + 9'(clen)) begin
							emit = 1'b1;
						end
					end
				end
				if (emit) begin
					phase_nx = mfnh_pkg::PH_DONE;
				end
			end
			// The last byte closes the buffer; undecided buffers report here.
			if (beat.is_final) begin
				if (phase_q != mfnh_pkg::PH_DONE) begin
					emit = 1'b1;
				end
				phase_nx       = mfnh_pkg::PH_OPEN;
				pos_nx         = '0;
				win_nx         = '0;
				name_ctl.clear = 1'b1;
			end
		end
	end

	// Framing state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfnh_pkg::PH_OPEN;
			pos_q   <= '0;
			win_q   <= '0;
		end else if (step) begin
			phase_q <= phase_nx;
			pos_q   <= pos_nx;
			win_q   <= win_nx;
		end
	end

	mfnh_name_check u_name_check (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (name_ctl),
		.stat   (name_stat)
	);

endmodule

// File: src/marker_framed_name_header_parser_core.sv
// ---------------------------------------------------------------------------
// Marker-framed name header parser core
// Checks a marker-framed filename header at the start of a byte stream and
// reports one result per buffer.
// ---------------------------------------------------------------------------
// Path: the deciding beat passes the input register, and its result is then
// loaded into the result register that drives the output port.
// Throughput: one byte per cycle; every stage takes a new beat each cycle
// while the result register is free or being drained.
// Reset: arst_n clears the pipeline valids, the parser state and the
// configuration registers to their reset values.
module marker_framed_name_header_parser_core #(
	parameter int unsigned MAX_MARKER_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  mfnh_pkg::in_beat_t            src_beat,
	output logic                          res_valid,
	input  logic                          res_stall,
	output mfnh_pkg::out_beat_t           res_beat,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mfnh_pkg::PADDR_W-1:0]  paddr,
	input  logic [mfnh_pkg::PDATA_W-1:0]  pwdata,
	output logic [mfnh_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	logic                valid_s1;
	mfnh_pkg::in_beat_t  beat_s1;
	logic                res_valid_q;
	mfnh_pkg::out_beat_t res_beat_q;
	logic                res_free;
	logic                step;
	logic                src_take;
	logic                emit;
	mfnh_pkg::out_beat_t result;
	mfnh_pkg::cfg_t      cfg;

	// The stage-one beat moves on whenever the result register can load.
	assign res_free  = !res_valid_q || !res_stall;
	assign step      = valid_s1 && res_free;
	assign src_stall = valid_s1 && !res_free;
	assign src_take  = src_valid && !src_stall;
	assign res_valid = res_valid_q;
	assign res_beat  = res_beat_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			beat_s1 <= src_beat;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_beat_q <= result;
		end
	end

	mfnh_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mfnh_frame #(
		.MAX_MARKER_BYTES (MAX_MARKER_BYTES)
	) u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.beat   (beat_s1),
		.cfg    (cfg),
		.emit   (emit),
		.result (result)
	);

endmodule

// File: tb/marker_framed_name_header_parser_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the marker-framed name header parser core
// Streams buffers of bytes through the parser under a series of register
// settings and checks every result beat against a cycle-free model of the
// header rules: marker matching, window limits and filename validation.
// ---------------------------------------------------------------------------
module marker_framed_name_header_parser_core_tb;

	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	// Printable characters that a filename must not hold: / \ : < > " | ? *
	localparam logic [7:0] PUNCT_BAD [0:8] = '{8'h2f, 8'h5c, 8'h3a, 8'h3c, 8'h3e, 8'h22,
		8'h7c, 8'h3f, 8'h2a};
	localparam int unsigned MARKER_CAP = 8;
	localparam int unsigned RANDOM_BEATS = 1550;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	mfnh_pkg::in_beat_t src_beat = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	mfnh_pkg::out_beat_t res_beat;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mfnh_pkg::PADDR_W-1:0] paddr = '0;
	logic [mfnh_pkg::PDATA_W-1:0] pwdata = '0;
	logic [mfnh_pkg::PDATA_W-1:0] prdata;
	logic pready;

	// Register copies used by the header model.
	logic [63:0] cfg_open_marker = '0;
	logic [3:0] cfg_open_len = 4'd0;
	logic [63:0] cfg_close_marker = '0;
	logic [3:0] cfg_close_len = 4'd1;
	logic [7:0] cfg_name_limit = 8'd255;

	// Header model state.
	mfnh_pkg::phase_t pr_phase;
	int unsigned pr_pos;
	logic [63:0] pr_window;
	logic [1:0] pr_utf_left;
	logic [20:0] pr_code;
	logic [1:0] pr_code_class;
	logic [8:0] pr_name_cnt;
	logic [7:0] pr_name_last;
	logic pr_dots_only;
	logic pr_name_bad;
	logic pr_decided;

	mfnh_pkg::in_beat_t byte_q[$];
	mfnh_pkg::out_beat_t results_q[$];
	logic [7:0] buf_bytes[$];

	int unsigned random_items = 0;
	int unsigned buffers_sent = 0;
	int unsigned beats_taken = 0;
	int unsigned results_seen = 0;
	int unsigned found_seen = 0;
	int unsigned settings_used = 0;
	int unsigned errors = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	marker_framed_name_header_parser_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_beat(src_beat),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_beat(res_beat),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Clock: 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic illegal_char(logic [7:0] c);
		logic hit;
		hit = (c < 8'h20) || (c == CH_DEL);
		foreach (PUNCT_BAD[i])
			if (c == PUNCT_BAD[i])
				hit = 1'b1;
		return hit;
	endfunction

	// Smallest code point that a sequence of the given class may encode.
	function automatic logic [20:0] class_floor(logic [1:0] cls);
		case (cls)
			2'd0: return 21'h0;
			2'd1: return 21'h80;
			2'd2: return 21'h800;
			default: return 21'h10000;
		endcase
	endfunction

	task automatic clear_buffer();
		pr_phase = mfnh_pkg::PH_OPEN;
		pr_pos = 0;
		pr_window = '0;
		pr_utf_left = '0;
		pr_code = '0;
		pr_code_class = '0;
		pr_name_cnt = '0;
		pr_name_last = '0;
		pr_dots_only = 1'b1;
		pr_name_bad = 1'b0;
		pr_decided = 1'b0;
	endtask

	task automatic enter_scan();
		pr_phase = mfnh_pkg::PH_SCAN;
		pr_pos = 0;
		pr_window = '0;
	endtask

	// Filename checker: one byte that has left the closing-marker window.
	task automatic name_push(logic [7:0] c);
		pr_name_cnt = pr_name_cnt + 9'd1;
		pr_name_last = c;
		if (c != CH_DOT)
			pr_dots_only = 1'b0;
		if (!pr_name_bad) begin
			if (pr_utf_left == 2'd0) begin
				if (illegal_char(c)) begin
					pr_name_bad = 1'b1;
				end else if (c >= 8'hc2 && c <= 8'hdf) begin
					pr_utf_left = 2'd1;
					pr_code = {16'd0, c[4:0]};
					pr_code_class = 2'd1;
				end else if (c >= 8'he0 && c <= 8'hef) begin
					pr_utf_left = 2'd2;
					pr_code = {17'd0, c[3:0]};
					pr_code_class = 2'd2;
				end else if (c >= 8'hf0 && c <= 8'hf4) begin
					pr_utf_left = 2'd3;
					pr_code = {18'd0, c[2:0]};
					pr_code_class = 2'd3;
				end else if (c >= 8'h80) begin
					pr_name_bad = 1'b1;
				end
			end else if (c[7:6] != 2'b10) begin
				pr_name_bad = 1'b1;
			end else begin
				pr_code = {pr_code[14:0], c[5:0]};
				pr_utf_left = pr_utf_left - 2'd1;
				// A finished sequence: reject overlongs, surrogates, out of range, C1.
				if (pr_utf_left == 2'd0 && (pr_code < class_floor(pr_code_class) ||
						pr_code > 21'h10ffff || (pr_code >= 21'hd800 && pr_code <= 21'hdfff) ||
						(pr_code >= 21'h80 && pr_code <= 21'h9f)))
					pr_name_bad = 1'b1;
			end
		end
	endtask

	// Advances the header model by one accepted beat and records any result.
	task automatic parse_header_byte(mfnh_pkg::in_beat_t bt);
		int unsigned olen;
		int unsigned clen;
		int unsigned lim;
		logic [63:0] mask;
		logic emit;
		mfnh_pkg::out_beat_t r;
		olen = (cfg_open_len > MARKER_CAP) ? MARKER_CAP : cfg_open_len;
		clen = (cfg_close_len > MARKER_CAP) ? MARKER_CAP : cfg_close_len;
		lim = cfg_name_limit;
		r = '0;
		emit = 1'b0;
		if (!pr_decided) begin
			if (clen == 0) begin
				emit = 1'b1;
			end else begin
				if (pr_phase == mfnh_pkg::PH_OPEN && pr_pos >= olen)
					enter_scan();
				if (pr_phase == mfnh_pkg::PH_OPEN) begin
					if (cfg_open_marker[8*pr_pos +: 8] != bt.data_byte) begin
						emit = 1'b1;
					end else begin
						pr_pos++;
						if (pr_pos >= olen)
							enter_scan();
					end
				end else begin
					mask = (clen >= 8) ? '1 : ((64'd1 << (8 * clen)) - 64'd1);
					if (pr_pos >= clen)
						name_push(pr_window[7:0]);
					pr_window = ((pr_window >> 8) | (64'(bt.data_byte) << (8 * (clen - 1)))) & mask;
					if (pr_pos + 1 >= clen && pr_window == (cfg_close_marker & mask)) begin
						emit = 1'b1;
						if (pr_name_cnt >= 1 && pr_name_cnt <= lim && !pr_name_bad &&
								pr_utf_left == 2'd0 && !(pr_dots_only && pr_name_cnt <= 2) &&
								pr_name_last != CH_DOT && pr_name_last != CH_SPACE) begin
							r.found = 1'b1;
							r.name_bytes = pr_name_cnt[7:0];
							r.header_bytes = 9'(olen + pr_name_cnt + clen);
						end
					end else begin
						pr_pos++;
						if (pr_pos >= lim + clen)
							emit = 1'b1;
					end
				end
			end
			if (emit) begin
				pr_decided = 1'b1;
				pr_phase = mfnh_pkg::PH_DONE;
			end
		end
		if (bt.is_final) begin
			if (!pr_decided)
				emit = 1'b1;
			clear_buffer();
		end
		if (emit)
			results_q.push_back(r);
	endtask

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= 50)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_result(mfnh_pkg::out_beat_t got);
		mfnh_pkg::out_beat_t want;
		if (results_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result found=%0d name=%0d header=%0d",
				got.found, got.name_bytes, got.header_bytes));
		end else begin
			want = results_q.pop_front();
			results_seen++;
			if (want.found)
				found_seen++;
			if (got.found !== want.found)
				report_mismatch($sformatf("result %0d found %0d, model %0d",
					results_seen, got.found, want.found));
			if (got.name_bytes !== want.name_bytes)
				report_mismatch($sformatf("result %0d name_bytes %0d, model %0d",
					results_seen, got.name_bytes, want.name_bytes));
			if (got.header_bytes !== want.header_bytes)
				report_mismatch($sformatf("result %0d header_bytes %0d, model %0d",
					results_seen, got.header_bytes, want.header_bytes));
		end
	endtask

	// Register write: setup phase, then access phase until pready.
	task automatic write_reg(logic [mfnh_pkg::REG_IDX_W-1:0] idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mfnh_pkg::REG_OPEN_MARKER: cfg_open_marker = val;
			mfnh_pkg::REG_OPEN_LENGTH: cfg_open_len = val[3:0];
			mfnh_pkg::REG_CLOSE_MARKER: cfg_close_marker = val;
			mfnh_pkg::REG_CLOSE_LENGTH: cfg_close_len = val[3:0];
			mfnh_pkg::REG_NAME_LIMIT: cfg_name_limit = val[7:0];
			default: ;
		endcase
	endtask

	// Fixed corner settings first, random ones after.
	task automatic pick_config(int unsigned k);
		logic [63:0] om;
		logic [63:0] cm;
		logic [3:0] ol;
		logic [3:0] cl;
		logic [7:0] lim;
		om = {$urandom, $urandom};
		cm = {$urandom, $urandom};
		if ($urandom_range(0, 2) == 0)
			cm = {8{8'($urandom_range(8'h21, 8'h7e))}};
		ol = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		cl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
		lim = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 40));
		case (k)
			0: begin
				om = 64'h3e3e_4d41_4e45_3c3c;
				ol = 4'd8;
				cm = 64'h3c3c_454d_414e_3e3e;
				cl = 4'd8;
				lim = 8'd255;
			end
			1: begin
				om = '1;
				ol = 4'd15;
				cm = '0;
				cl = 4'd15;
				lim = 8'd1;
			end
			2: begin
				ol = 4'd0;
				cm = 64'h23;
				cl = 4'd1;
				lim = 8'd255;
			end
			3: begin
				ol = 4'd2;
				cl = 4'd0;
				lim = 8'd20;
			end
			4: begin
				ol = 4'd1;
				cl = 4'd2;
				lim = 8'd0;
			end
			5: begin
				om = 64'h7b7b7b;
				ol = 4'd3;
				cm = 64'h2323;
				cl = 4'd2;
				lim = 8'd16;
			end
			6: begin
				om = 64'hff;
				ol = 4'd1;
				cm = 64'h00ff_80c0;
				cl = 4'd4;
				lim = 8'd255;
			end
			default: ;
		endcase
		write_reg(mfnh_pkg::REG_OPEN_MARKER, om);
		write_reg(mfnh_pkg::REG_OPEN_LENGTH, 64'(ol));
		write_reg(mfnh_pkg::REG_CLOSE_MARKER, cm);
		write_reg(mfnh_pkg::REG_CLOSE_LENGTH, 64'(cl));
		write_reg(mfnh_pkg::REG_NAME_LIMIT, 64'(lim));
		settings_used++;
	endtask

	// Moves the staged buffer into the send queue, last byte flagged.
	task automatic flush_buffer();
		mfnh_pkg::in_beat_t bt;
		foreach (buf_bytes[i]) begin
			bt.data_byte = buf_bytes[i];
			bt.is_final = (i == buf_bytes.size() - 1);
			byte_q.push_back(bt);
		end
		buf_bytes.delete();
		buffers_sent++;
	endtask

	task automatic queue_packed(logic [63:0] bytes, int unsigned n);
		for (int i = 0; i < n; i++)
			buf_bytes.push_back(bytes[8*i +: 8]);
		flush_buffer();
	endtask

	// One piece of a filename: plain ASCII, a good UTF-8 sequence, or a bad form.
	task automatic add_name_unit();
		int unsigned sel;
		logic [20:0] cp;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			do c = 8'($urandom_range(8'h20, 8'h7e)); while (illegal_char(c));
			buf_bytes.push_back(c);
		end else if (sel < 80) begin
			case ($urandom_range(1, 3))
				1: cp = 21'($urandom_range(21'ha0, 21'h7ff));
				2: do cp = 21'($urandom_range(21'h800, 21'hffff));
					while (cp >= 21'hd800 && cp <= 21'hdfff);
				default: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
			endcase
			if (cp < 21'h800) begin
				buf_bytes.push_back({3'b110, cp[10:6]});
			end else if (cp < 21'h10000) begin
				buf_bytes.push_back({4'b1110, cp[15:12]});
				buf_bytes.push_back({2'b10, cp[11:6]});
			end else begin
				buf_bytes.push_back({5'b11110, cp[20:18]});
				buf_bytes.push_back({2'b10, cp[17:12]});
				buf_bytes.push_back({2'b10, cp[11:6]});
			end
			buf_bytes.push_back({2'b10, cp[5:0]});
		end else if (sel < 88) begin
			buf_bytes.push_back(8'($urandom));
		end else begin
			case ($urandom_range(0, 7))
				0: begin
					c = 8'($urandom_range(0, 10));
					buf_bytes.push_back((c < 9) ? PUNCT_BAD[c] :
						(c == 9) ? 8'($urandom_range(0, 31)) : CH_DEL);
				end
				// Overlong two-byte lead.
				1: begin
					buf_bytes.push_back(8'($urandom_range(8'hc0, 8'hc1)));
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				end
				// Overlong three- or four-byte form.
				2: begin
					buf_bytes.push_back($urandom_range(0, 1) ? 8'he0 : 8'hf0);
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'h8f)));
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				end
				// Surrogate half.
				3: begin
					buf_bytes.push_back(8'hed);
					buf_bytes.push_back(8'($urandom_range(8'ha0, 8'hbf)));
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				end
				// Beyond the last code point.
				4: begin
					buf_bytes.push_back(8'hf4);
					buf_bytes.push_back(8'($urandom_range(8'h90, 8'hbf)));
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				end
				// C1 control character.
				5: begin
					buf_bytes.push_back(8'hc2);
					buf_bytes.push_back(8'($urandom_range(8'h80, 8'h9f)));
				end
				6: buf_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				// Sequence cut short by an ASCII byte.
				default: begin
					buf_bytes.push_back(8'he1);
					buf_bytes.push_back(8'h61);
				end
			endcase
		end
	endtask

	task automatic build_name(int unsigned lim);
		int unsigned start;
		int unsigned target;
		int unsigned pick;
		start = buf_bytes.size();
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			buf_bytes.push_back(CH_DOT);
		end else if (pick < 6) begin
			buf_bytes.push_back(CH_DOT);
			buf_bytes.push_back(CH_DOT);
		end else if (pick >= 9) begin
			if ($urandom_range(0, 24) == 0)
				target = $urandom_range((lim > 2) ? lim - 2 : 1, lim + 1);
			else
				target = $urandom_range(1, (lim < 12) ? lim : 12);
			while (buf_bytes.size() - start < target)
				add_name_unit();
			// A name ending in a dot or a space.
			if (pick < 15)
				buf_bytes[buf_bytes.size() - 1] = $urandom_range(0, 1) ? CH_DOT : CH_SPACE;
		end
	endtask

	// One buffer: mostly a well-formed header, some broken ones and plain noise.
	task automatic queue_buffer();
		int unsigned olen;
		int unsigned clen;
		int unsigned kind;
		int unsigned cut;
		olen = (cfg_open_len > MARKER_CAP) ? MARKER_CAP : cfg_open_len;
		clen = (cfg_close_len > MARKER_CAP) ? MARKER_CAP : cfg_close_len;
		kind = $urandom_range(0, 99);
		if (kind < 5) begin
			repeat ($urandom_range(1, 12))
				buf_bytes.push_back(8'($urandom));
		end else begin
			for (int i = 0; i < olen; i++)
				buf_bytes.push_back(cfg_open_marker[8*i +: 8]);
			if (kind < 12 && olen > 0) begin
				cut = $urandom_range(0, olen - 1);
				buf_bytes[cut] = buf_bytes[cut] ^ 8'($urandom_range(1, 255));
			end
			build_name((cfg_name_limit == 0) ? 3 : cfg_name_limit);
			for (int i = 0; i < clen; i++)
				buf_bytes.push_back(cfg_close_marker[8*i +: 8]);
			// Buffer that ends before its header is complete.
			if (kind >= 12 && kind < 20 && buf_bytes.size() > 1) begin
				cut = $urandom_range(1, buf_bytes.size() - 1);
				while (buf_bytes.size() > cut)
					void'(buf_bytes.pop_back());
			end
		end
		random_items += buf_bytes.size();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4))
				buf_bytes.push_back(8'($urandom));
		flush_buffer();
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (byte_q.size() != 0 || src_valid || results_q.size() != 0);
	endtask

	// Source side: bursts of beats separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && !src_stall) begin
				parse_header_byte(src_beat);
				beats_taken++;
			end
			if (!src_valid || !src_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					src_valid <= 1'b0;
				end else if (byte_q.size() > 0) begin
					src_beat <= byte_q.pop_front();
					src_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// Result side: checks each beat and stalls in changing patterns.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_result(res_beat);
			if (stall_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(24, 200);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				STALL_NONE: res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
				default: res_stall <= ((stall_left % 7) < 3);
			endcase
		end
	end

	// Main sequence: reset, directed buffers, then random buffers per setting.
	initial begin
		int unsigned setting;
		int unsigned budget;
		clear_buffer();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: no opening marker, a single zero byte closes the name.
		queue_packed(64'h00_41, 2);
		queue_packed(64'h00_2e, 2);
		queue_packed(64'h00_2e2e, 3);
		queue_packed(64'h00, 1);
		queue_packed(64'hff_61, 2);
		queue_packed(64'h00_af_c0, 3);
		queue_packed(64'h00_80_a0_ed, 4);
		queue_packed(64'h00_80_80_90_f4, 5);
		queue_packed(64'h00_85_c2, 3);
		wait_drained();
		repeat (4) @(negedge clk);

		setting = 0;
		while (random_items < RANDOM_BEATS) begin
			pick_config(setting);
			setting++;
			@(negedge clk);
			budget = random_items + $urandom_range(80, 200);
			while (random_items < budget) begin
				if ($urandom_range(0, 29) == 0)
					wait_drained();
				queue_buffer();
			end
			wait_drained();
			repeat (4) @(negedge clk);
		end

		repeat (16) @(negedge clk);
		$display("Sent %0d buffers (%0d beats) under %0d register settings after reset.",
			buffers_sent, beats_taken, settings_used);
		$display("Checked %0d results, %0d of them with a valid header.", results_seen, found_seen);
		if (errors == 0) begin
			$display("marker_framed_name_header_parser_core_tb passed");
		end else begin
			$display("marker_framed_name_header_parser_core_tb failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#6_000_000;
		$display("marker_framed_name_header_parser_core_tb failed");
		$finish;
	end

endmodule

// File: files.f
src/mfnh_pkg.sv
src/mfnh_cfg_regs.sv
src/mfnh_name_check.sv
src/mfnh_frame.sv
src/marker_framed_name_header_parser_core.sv
tb/marker_framed_name_header_parser_core_tb.sv
